FILE: hdl/tlg_pkg.sv
// Shared types and constants for the toroidal life grid.
`timescale 1ns / 1ps

package tlg_pkg;

  // Fixed widths of the item fields and of the grid size register.
  localparam int COORD_W = 6;
  localparam int GS_W    = 7;
  localparam int OP_W    = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_SET_ALIVE = 2'd0;
  localparam logic [OP_W-1:0] OP_SET_DEAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_ADVANCE   = 2'd2;
  localparam logic [OP_W-1:0] OP_READ      = 2'd3;

  // Configuration port layout: one 32-bit register per word.
  localparam int              PADDR_W       = 3;
  localparam int              PDATA_W       = 32;
  localparam logic            REG_GRID_SIZE = 1'b0;
  localparam logic [GS_W-1:0] GS_RESET      = 7'd64;

  // B3/S23 rule and neighbor count width.
  localparam int              NCNT_W     = 4;
  localparam logic [NCNT_W-1:0] N_BIRTH  = 4'd3;
  localparam logic [NCNT_W-1:0] N_SURV   = 4'd2;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
  } in_item_t;

  typedef struct packed {
    logic cell_alive;
    logic ignored;
  } out_item_t;

endpackage

FILE: hdl/tlg_row_store.sv
// Row memory of the cell grid with per-row valid flags cleared at reset.
`timescale 1ns / 1ps

module tlg_row_store #(
  parameter int MAX_SIZE = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [$clog2(MAX_SIZE)-1:0] rd_addr_i,
  output logic [MAX_SIZE-1:0]         rd_data_o,
  input  logic                        wr_en_i,
  input  logic [$clog2(MAX_SIZE)-1:0] wr_addr_i,
  input  logic [MAX_SIZE-1:0]         wr_data_i
);

  logic [MAX_SIZE-1:0] mem_q [MAX_SIZE];
  logic [MAX_SIZE-1:0] valid_q;
  logic [MAX_SIZE-1:0] rd_data_q;
  logic                rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // A row never written since reset reads as all dead.
  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

FILE: hdl/tlg_mod_unit.sv
// Two-lane restoring remainder unit that reduces row and column by the grid size.
`timescale 1ns / 1ps

module tlg_mod_unit #(
  parameter int MAX_SIZE = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [tlg_pkg::COORD_W-1:0]        row_i,
  input  logic [tlg_pkg::COORD_W-1:0]        col_i,
  input  logic [$clog2(MAX_SIZE+1)-1:0]      size_i,
  output logic                               done_o,
  output logic [$clog2(MAX_SIZE)-1:0]        row_o,
  output logic [$clog2(MAX_SIZE)-1:0]        col_o
);

  localparam int CW   = $clog2(MAX_SIZE);
  localparam int SW   = $clog2(MAX_SIZE + 1);
  localparam int SW1  = SW + 1;
  localparam int CNTW = $clog2(tlg_pkg::COORD_W + 1);

  logic                        run_q, run_d;
  logic                        done_q, done_d;
  logic [CNTW-1:0]             cnt_q, cnt_d;
  logic [tlg_pkg::COORD_W-1:0] sr_q, sr_d, sc_q, sc_d;
  logic [SW-1:0]               rr_q, rr_d, rc_q, rc_d;
  logic [SW1-1:0]              tr, tc, div;

  assign div = SW1'(size_i);
  assign tr  = {rr_q, sr_q[tlg_pkg::COORD_W-1]};
  assign tc  = {rc_q, sc_q[tlg_pkg::COORD_W-1]};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sr_d   = sr_q;
    sc_d   = sc_q;
    rr_d   = rr_q;
    rc_d   = rc_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CNTW'(tlg_pkg::COORD_W);
      sr_d  = row_i;
      sc_d  = col_i;
      rr_d  = '0;
      rc_d  = '0;
    end else if (run_q) begin
      // One bit of each dividend per cycle, most significant first.
      sr_d  = sr_q << 1;
      sc_d  = sc_q << 1;
      rr_d  = (tr >= div) ? SW'(tr - div) : SW'(tr);
      rc_d  = (tc >= div) ? SW'(tc - div) : SW'(tc);
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
    sc_q <= sc_d;
    rr_q <= rr_d;
    rc_q <= rc_d;
  end

  assign done_o = done_q;
  assign row_o  = CW'(rr_q);
  assign col_o  = CW'(rc_q);

endmodule

FILE: hdl/tlg_next_row.sv
// Next-generation row from a three-row window, with column wraparound at the grid size.
`timescale 1ns / 1ps

module tlg_next_row #(
  parameter int MAX_SIZE = 64
) (
  input  logic [MAX_SIZE-1:0]           prev_i,
  input  logic [MAX_SIZE-1:0]           cur_i,
  input  logic [MAX_SIZE-1:0]           nxt_i,
  input  logic [$clog2(MAX_SIZE+1)-1:0] size_i,
  output logic [MAX_SIZE-1:0]           row_o
);

  localparam int CW = $clog2(MAX_SIZE);
  localparam int SW = $clog2(MAX_SIZE + 1);

  logic [CW-1:0] last_idx;
  logic          prev_last, cur_last, nxt_last;

  assign last_idx  = CW'(size_i - SW'(1));
  assign prev_last = prev_i[last_idx];
  assign cur_last  = cur_i[last_idx];
  assign nxt_last  = nxt_i[last_idx];

  for (genvar c = 0; c < MAX_SIZE; c++) begin : g_col
    logic                              pl, cl, nl, pr, cr, nr;
    logic [tlg_pkg::NCNT_W-1:0]        cnt;
    logic                              live;

    if (c == 0) begin : g_left_wrap
      assign pl = prev_last;
      assign cl = cur_last;
      assign nl = nxt_last;
    end else begin : g_left
      assign pl = prev_i[c-1];
      assign cl = cur_i[c-1];
      assign nl = nxt_i[c-1];
    end

    if (c == MAX_SIZE - 1) begin : g_right_wrap
      assign pr = prev_i[0];
      assign cr = cur_i[0];
      assign nr = nxt_i[0];
    end else begin : g_right
      logic at_edge;
      assign at_edge = (SW'(c + 1) == size_i);
      assign pr = at_edge ? prev_i[0] : prev_i[c+1];
      assign cr = at_edge ? cur_i[0]  : cur_i[c+1];
      assign nr = at_edge ? nxt_i[0]  : nxt_i[c+1];
    end

    assign cnt = tlg_pkg::NCNT_W'(pl) + tlg_pkg::NCNT_W'(prev_i[c]) +
                 tlg_pkg::NCNT_W'(pr) + tlg_pkg::NCNT_W'(cl) +
                 tlg_pkg::NCNT_W'(cr) + tlg_pkg::NCNT_W'(nl) +
                 tlg_pkg::NCNT_W'(nxt_i[c]) + tlg_pkg::NCNT_W'(nr);
    assign live = (cnt == tlg_pkg::N_BIRTH) || (cur_i[c] && (cnt == tlg_pkg::N_SURV));

    // Columns outside the active square keep their value.
    assign row_o[c] = (SW'(c) < size_i) ? live : cur_i[c];
  end

endmodule

FILE: hdl/toroidal_life_grid_unit.sv
// Top level of the toroidal life grid: sequencer, configuration port and result register.
`timescale 1ns / 1ps

// Command-style Life grid on a torus. An item is taken when start is high and busy is low;
// its single result appears on result_o for one cycle with out_valid_o high and must be
// captured then, since the block cannot be held off. A set reads its row and writes it back
// before the strobe (an item whose coordinates fall outside the grid is ignored without a
// memory access), a read runs both coordinates through a six-step remainder unit, and an
// advance fetches the last and first rows and then sweeps the grid: the grid lives in a row
// memory with one read and one write port, and the sweep writes one new row per cycle.
// Reset clears the grid at once through per-row valid flags, so no clearing pass is needed.
// Write grid_size only while busy is low and no result is pending.
module toroidal_life_grid_unit #(
  parameter int MAX_SIZE = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  tlg_pkg::in_item_t             item_i,
  output logic                          out_valid_o,
  output tlg_pkg::out_item_t            result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlg_pkg::PADDR_W-1:0]   paddr,
  input  logic [tlg_pkg::PDATA_W-1:0]   pwdata,
  output logic [tlg_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int CW  = $clog2(MAX_SIZE);
  localparam int SW  = $clog2(MAX_SIZE + 1);
  localparam int SW1 = SW + 1;
  localparam int XW  = (SW > tlg_pkg::GS_W) ? SW : tlg_pkg::GS_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SET_WR = 3'd1;
  localparam logic [2:0] ST_MOD    = 3'd2;
  localparam logic [2:0] ST_RD_OUT = 3'd3;
  localparam logic [2:0] ST_ADV_1  = 3'd4;
  localparam logic [2:0] ST_ADV_2  = 3'd5;
  localparam logic [2:0] ST_LOOP   = 3'd6;

  logic [2:0]                   state_q, state_d;
  logic [tlg_pkg::GS_W-1:0]     grid_size_q, grid_size_d;
  logic [tlg_pkg::OP_W-1:0]     op_q, op_d;
  logic [CW-1:0]                row_q, row_d, col_q, col_d;
  logic [SW-1:0]                cnt_q, cnt_d;
  logic [MAX_SIZE-1:0]          prev_q, prev_d, cur_q, cur_d, first_q, first_d;
  logic                         out_valid_q, out_valid_d;
  tlg_pkg::out_item_t           result_q, result_d;

  logic [XW-1:0]                gs_ext;
  logic [SW-1:0]                size;
  logic                         accept, out_of_grid, cfg_write;
  logic [SW1-1:0]               cnt_p1, cnt_p2;
  logic [MAX_SIZE-1:0]          nxt_row, gen_row;

  logic                         rd_en, wr_en;
  logic [CW-1:0]                rd_addr, wr_addr;
  logic [MAX_SIZE-1:0]          rd_data, wr_data;

  logic                         mod_start, mod_done;
  logic [CW-1:0]                mod_row, mod_col;

  // Effective size: zero counts as one, and values past the grid storage saturate.
  assign gs_ext = XW'(grid_size_q);
  always_comb begin
    if (grid_size_q == '0) begin
      size = SW'(1);
    end else if (gs_ext > XW'(MAX_SIZE)) begin
      size = SW'(MAX_SIZE);
    end else begin
      size = SW'(gs_ext);
    end
  end

  assign accept      = start && !busy;
  assign out_of_grid = (XW'(item_i.row) >= XW'(size)) || (XW'(item_i.column) >= XW'(size));
  assign cnt_p1      = SW1'(cnt_q) + SW1'(1);
  assign cnt_p2      = SW1'(cnt_q) + SW1'(2);
  // The row below the last one is the original first row, saved before it was overwritten.
  assign nxt_row     = (cnt_p1 == SW1'(size)) ? first_q : rd_data;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == tlg_pkg::REG_GRID_SIZE);
  assign grid_size_d = cfg_write ? pwdata[tlg_pkg::GS_W-1:0] : grid_size_q;
  assign prdata    = (paddr[2] == tlg_pkg::REG_GRID_SIZE) ?
                     tlg_pkg::PDATA_W'(grid_size_q) : '0;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    row_d       = row_q;
    col_d       = col_q;
    cnt_d       = cnt_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    first_d     = first_q;
    out_valid_d = 1'b0;
    result_d    = result_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = rd_data;
    mod_start   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d  = item_i.operation;
          row_d = CW'(item_i.row);
          col_d = CW'(item_i.column);
          case (item_i.operation)
            tlg_pkg::OP_SET_ALIVE, tlg_pkg::OP_SET_DEAD: begin
              if (out_of_grid) begin
                out_valid_d         = 1'b1;
                result_d.cell_alive = 1'b0;
                result_d.ignored    = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rd_addr = CW'(item_i.row);
                state_d = ST_SET_WR;
              end
            end
            tlg_pkg::OP_ADVANCE: begin
              rd_en   = 1'b1;
              rd_addr = CW'(size - SW'(1));
              state_d = ST_ADV_1;
            end
            default: begin
              mod_start = 1'b1;
              state_d   = ST_MOD;
            end
          endcase
        end
      end
      ST_SET_WR: begin
        wr_en               = 1'b1;
        wr_addr             = row_q;
        wr_data[col_q]      = (op_q == tlg_pkg::OP_SET_ALIVE);
        out_valid_d         = 1'b1;
        result_d.cell_alive = (op_q == tlg_pkg::OP_SET_ALIVE);
        result_d.ignored    = 1'b0;
        state_d             = ST_IDLE;
      end
      ST_MOD: begin
        if (mod_done) begin
          rd_en   = 1'b1;
          rd_addr = mod_row;
          col_d   = mod_col;
          state_d = ST_RD_OUT;
        end
      end
      ST_RD_OUT: begin
        out_valid_d         = 1'b1;
        result_d.cell_alive = rd_data[col_q];
        result_d.ignored    = 1'b0;
        state_d             = ST_IDLE;
      end
      ST_ADV_1: begin
        prev_d  = rd_data;
        rd_en   = 1'b1;
        rd_addr = '0;
        state_d = ST_ADV_2;
      end
      ST_ADV_2: begin
        cur_d   = rd_data;
        first_d = rd_data;
        rd_en   = 1'b1;
        rd_addr = CW'(1);
        cnt_d   = '0;
        state_d = ST_LOOP;
      end
      ST_LOOP: begin
        // Write row cnt while the row two below it is fetched.
        wr_en   = 1'b1;
        wr_addr = CW'(cnt_q);
        wr_data = gen_row;
        prev_d  = cur_q;
        cur_d   = nxt_row;
        cnt_d   = SW'(cnt_p1);
        if (cnt_p2 < SW1'(size)) begin
          rd_en   = 1'b1;
          rd_addr = CW'(cnt_p2);
        end
        if (cnt_p1 == SW1'(size)) begin
          out_valid_d         = 1'b1;
          result_d.cell_alive = 1'b0;
          result_d.ignored    = 1'b0;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      grid_size_q <= tlg_pkg::GS_RESET;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      grid_size_q <= grid_size_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    row_q    <= row_d;
    col_q    <= col_d;
    prev_q   <= prev_d;
    cur_q    <= cur_d;
    first_q  <= first_d;
    result_q <= result_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  tlg_row_store #(
    .MAX_SIZE (MAX_SIZE)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  tlg_mod_unit #(
    .MAX_SIZE (MAX_SIZE)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .row_i   (item_i.row),
    .col_i   (item_i.column),
    .size_i  (size),
    .done_o  (mod_done),
    .row_o   (mod_row),
    .col_o   (mod_col)
  );

  tlg_next_row #(
    .MAX_SIZE (MAX_SIZE)
  ) u_next_row (
    .prev_i (prev_q),
    .cur_i  (cur_q),
    .nxt_i  (nxt_row),
    .size_i (size),
    .row_o  (gen_row)
  );

endmodule

FILE: test/tb.sv
// Self-checking testbench for the toroidal life grid: directed and random commands, grid size sweep.
`timescale 1ns / 1ps

module tb;

  localparam int GRID_MAX = 64;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  tlg_pkg::in_item_t           item_i;
  logic                        out_valid_o;
  tlg_pkg::out_item_t          result_o;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [tlg_pkg::PADDR_W-1:0] paddr;
  logic [tlg_pkg::PDATA_W-1:0] pwdata;
  logic [tlg_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  toroidal_life_grid_unit #(
    .MAX_SIZE(GRID_MAX)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .out_valid_o(out_valid_o),
    .result_o   (result_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Predicted grid contents and the grid size register as last written.
  logic [GRID_MAX-1:0]      cell_map [GRID_MAX];
  logic [tlg_pkg::GS_W-1:0] grid_size_reg;

  tlg_pkg::in_item_t  pending_cmds [$];
  tlg_pkg::out_item_t expected_results [$];

  int unsigned n_queued;
  int unsigned n_issued;
  int unsigned n_taken;
  int unsigned n_results;
  int unsigned n_generations;
  int unsigned n_ignored;
  int unsigned n_reads;
  int unsigned n_size_writes;
  int unsigned mismatch_cnt;
  int unsigned gap_pct;
  int unsigned gap_left;

  int unsigned phase_sizes [16] = '{3, 5, 1, 8, 2, 12, 0, 6, 16, 65, 4, 10, 127, 7, 32, 64};

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("toroidal_life_grid_unit test failed");
    $finish;
  end

  function automatic void flag_mismatch(string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("MISMATCH: %s", what);
  endfunction

  function automatic int unsigned active_size();
    if (grid_size_reg == 0) return 1;
    if (grid_size_reg > GRID_MAX) return GRID_MAX;
    return grid_size_reg;
  endfunction

  // Applies one command to the predicted grid and returns the result it should produce.
  function automatic tlg_pkg::out_item_t predict_cell_result(tlg_pkg::in_item_t cmd);
    tlg_pkg::out_item_t  res;
    int unsigned         s, r, c, rr, cc, nbrs;
    int                  dr, dc;
    logic [GRID_MAX-1:0] nxt [GRID_MAX];
    s   = active_size();
    res = '0;
    case (cmd.operation)
      tlg_pkg::OP_SET_ALIVE, tlg_pkg::OP_SET_DEAD: begin
        if (cmd.row >= s || cmd.column >= s) begin
          res.ignored = 1'b1;
        end else begin
          cell_map[cmd.row][cmd.column] = (cmd.operation == tlg_pkg::OP_SET_ALIVE);
          res.cell_alive = cell_map[cmd.row][cmd.column];
        end
      end
      tlg_pkg::OP_ADVANCE: begin
        nxt = cell_map;
        for (r = 0; r < s; r++) begin
          for (c = 0; c < s; c++) begin
            nbrs = 0;
            // Each neighbor position wraps on its own, so tiny grids count cells repeatedly.
            for (dr = -1; dr <= 1; dr++) begin
              for (dc = -1; dc <= 1; dc++) begin
                if (dr != 0 || dc != 0) begin
                  rr = (dr < 0) ? (r + s - 1) % s : ((dr > 0) ? (r + 1) % s : r);
                  cc = (dc < 0) ? (c + s - 1) % s : ((dc > 0) ? (c + 1) % s : c);
                  nbrs += cell_map[rr][cc];
                end
              end
            end
            if (cell_map[r][c]) nxt[r][c] = (nbrs == 2 || nbrs == 3);
            else nxt[r][c] = (nbrs == 3);
          end
        end
        cell_map = nxt;
      end
      tlg_pkg::OP_READ: begin
        res.cell_alive = cell_map[cmd.row % s][cmd.column % s];
      end
      default: ;
    endcase
    return res;
  endfunction

  // Driver: presents the next queued command, with random bursts of idle cycles between them.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!start || n_taken == n_issued) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left--;
        end else if (pending_cmds.size() != 0) begin
          item_i <= pending_cmds.pop_front();
          start  <= 1'b1;
          n_issued++;
          if (gap_pct != 0 && $urandom_range(99) < gap_pct) gap_left = $urandom_range(1, 14);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result strobe, then records the command taken at this edge.
  always @(posedge clk_i) begin
    tlg_pkg::out_item_t want;
    tlg_pkg::in_item_t  cmd;
    if (rst_ni) begin
      if (out_valid_o) begin
        n_results++;
        if (expected_results.size() == 0) begin
          flag_mismatch($sformatf("result alive=%b ignored=%b with nothing expected",
                                  result_o.cell_alive, result_o.ignored));
        end else begin
          want = expected_results.pop_front();
          if (result_o.cell_alive !== want.cell_alive || result_o.ignored !== want.ignored)
            flag_mismatch($sformatf(
              "result %0d: expected alive=%b ignored=%b, got alive=%b ignored=%b",
              n_results, want.cell_alive, want.ignored,
              result_o.cell_alive, result_o.ignored));
        end
      end
      if (start && !busy) begin
        cmd  = item_i;
        want = predict_cell_result(cmd);
        expected_results.push_back(want);
        n_taken++;
        if (cmd.operation == tlg_pkg::OP_ADVANCE) n_generations++;
        if (cmd.operation == tlg_pkg::OP_READ) n_reads++;
        if (want.ignored) n_ignored++;
      end
    end
  end

  task automatic push_cmd(logic [tlg_pkg::OP_W-1:0] op, int unsigned r, int unsigned c);
    tlg_pkg::in_item_t cmd;
    cmd.operation = op;
    cmd.row       = tlg_pkg::COORD_W'(r);
    cmd.column    = tlg_pkg::COORD_W'(c);
    pending_cmds.push_back(cmd);
    n_queued++;
  endtask

  task automatic wait_grid_idle();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || n_issued != n_taken || expected_results.size() != 0
           || busy || start);
    repeat (8) @(negedge clk_i);
  endtask

  // APB read of the grid size register; called at a falling edge with the port idle.
  task automatic check_grid_size_reg(logic [tlg_pkg::GS_W-1:0] gs);
    logic [tlg_pkg::PDATA_W-1:0] want;
    want         = '0;
    want[tlg_pkg::GS_W-1:0] = gs;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= tlg_pkg::PADDR_W'({tlg_pkg::REG_GRID_SIZE, 2'b00});
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    if (prdata !== want)
      flag_mismatch($sformatf("grid_size readback: expected %0d, got %0d", want, prdata));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Waits for the grid to go idle, writes grid_size with random upper bits, and reads it back.
  task automatic set_grid_size(logic [tlg_pkg::GS_W-1:0] gs);
    logic [tlg_pkg::PDATA_W-1:0] wdata;
    wait_grid_idle();
    wdata           = $urandom();
    wdata[tlg_pkg::GS_W-1:0] = gs;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= tlg_pkg::PADDR_W'({tlg_pkg::REG_GRID_SIZE, 2'b00});
    pwdata  <= wdata;
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    grid_size_reg = gs;
    n_size_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    check_grid_size_reg(gs);
    @(posedge clk_i);
  endtask

  // Random commands: mostly seeded patterns that evolve over a few generations, some noise.
  task automatic queue_life_phase(int unsigned count);
    int unsigned s, first, pick, br, bc;
    s     = active_size();
    first = n_queued;
    while (n_queued - first < count) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        repeat ($urandom_range(2, 14))
          push_cmd(($urandom_range(9) == 0) ? tlg_pkg::OP_SET_DEAD : tlg_pkg::OP_SET_ALIVE,
                   $urandom_range(s - 1), $urandom_range(s - 1));
        if (s >= 4 && $urandom_range(2) == 0) begin
          // A glider placed anywhere, wrapped onto the torus.
          br = $urandom_range(s - 1);
          bc = $urandom_range(s - 1);
          push_cmd(tlg_pkg::OP_SET_ALIVE, br, (bc + 1) % s);
          push_cmd(tlg_pkg::OP_SET_ALIVE, (br + 1) % s, (bc + 2) % s);
          push_cmd(tlg_pkg::OP_SET_ALIVE, (br + 2) % s, bc);
          push_cmd(tlg_pkg::OP_SET_ALIVE, (br + 2) % s, (bc + 1) % s);
          push_cmd(tlg_pkg::OP_SET_ALIVE, (br + 2) % s, (bc + 2) % s);
        end
        repeat ($urandom_range(1, 5)) begin
          push_cmd(tlg_pkg::OP_ADVANCE, $urandom_range(63), $urandom_range(63));
          repeat ($urandom_range(0, 3))
            push_cmd(tlg_pkg::OP_READ, $urandom_range(63), $urandom_range(63));
        end
      end else if (pick < 84 && s < GRID_MAX) begin
        if ($urandom_range(1) == 0)
          push_cmd(tlg_pkg::OP_W'($urandom_range(1)), $urandom_range(GRID_MAX - 1, s),
                   $urandom_range(63));
        else
          push_cmd(tlg_pkg::OP_W'($urandom_range(1)), $urandom_range(63),
                   $urandom_range(GRID_MAX - 1, s));
      end else begin
        push_cmd(tlg_pkg::OP_W'($urandom_range(3)), $urandom_range(63), $urandom_range(63));
      end
    end
  endtask

  initial begin
    int p;
    rst_ni  = 1'b0;
    start   = 1'b0;
    item_i  = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    foreach (cell_map[i]) cell_map[i] = '0;
    grid_size_reg = tlg_pkg::GS_RESET;
    gap_pct  = 0;
    gap_left = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    @(negedge clk_i);
    check_grid_size_reg(tlg_pkg::GS_RESET);
    @(posedge clk_i);

    // Reset size: corners of the full grid, then an isolated cell dies.
    push_cmd(tlg_pkg::OP_SET_ALIVE, 0, 0);
    push_cmd(tlg_pkg::OP_SET_ALIVE, 63, 63);
    push_cmd(tlg_pkg::OP_READ, 63, 63);
    push_cmd(tlg_pkg::OP_SET_DEAD, 63, 63);
    push_cmd(tlg_pkg::OP_READ, 0, 0);
    push_cmd(tlg_pkg::OP_ADVANCE, 63, 63);
    push_cmd(tlg_pkg::OP_READ, 0, 0);

    // A single-cell torus counts the cell as all eight of its own neighbors.
    set_grid_size(7'd1);
    push_cmd(tlg_pkg::OP_SET_ALIVE, 0, 0);
    push_cmd(tlg_pkg::OP_SET_ALIVE, 0, 1);
    push_cmd(tlg_pkg::OP_SET_DEAD, 1, 0);
    push_cmd(tlg_pkg::OP_READ, 63, 63);
    push_cmd(tlg_pkg::OP_ADVANCE, 0, 0);
    push_cmd(tlg_pkg::OP_READ, 0, 0);

    set_grid_size(7'd2);
    push_cmd(tlg_pkg::OP_SET_ALIVE, 0, 0);
    push_cmd(tlg_pkg::OP_SET_ALIVE, 1, 1);
    push_cmd(tlg_pkg::OP_ADVANCE, 0, 0);
    push_cmd(tlg_pkg::OP_READ, 3, 2);

    // Zero behaves as one, and values above the maximum saturate.
    set_grid_size(7'd0);
    push_cmd(tlg_pkg::OP_SET_ALIVE, 0, 0);
    push_cmd(tlg_pkg::OP_SET_DEAD, 0, 1);
    set_grid_size(7'd127);
    push_cmd(tlg_pkg::OP_SET_ALIVE, 63, 0);
    push_cmd(tlg_pkg::OP_READ, 63, 0);
    push_cmd(tlg_pkg::OP_ADVANCE, 0, 0);

    for (p = 0; p < 16; p++) begin
      set_grid_size(tlg_pkg::GS_W'(phase_sizes[p]));
      gap_pct = (p == 15 || p % 3 == 2) ? 0 : 30;
      queue_life_phase((active_size() >= 32) ? 60 : 125);
    end

    wait_grid_idle();
    repeat (20) @(negedge clk_i);
    if (expected_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("Covered %0d commands over %0d grid size writes: %0d generations, %0d reads,",
             n_taken, n_size_writes, n_generations, n_reads);
    $display("%0d out-of-grid sets; %0d results checked, %0d mismatches.",
             n_ignored, n_results, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("toroidal_life_grid_unit test passed");
    end else begin
      $display("toroidal_life_grid_unit test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/tlg_pkg.sv
hdl/tlg_row_store.sv
hdl/tlg_mod_unit.sv
hdl/tlg_next_row.sv
hdl/toroidal_life_grid_unit.sv
test/tb.sv
